FILE: design/fmh_pkg.sv
// ----------------------------------------------------------------------------
// fmh_pkg: shared types and constants of the frontier min-heap
// Entry layout, command and status codes, and the item and result structs.
// ----------------------------------------------------------------------------
package fmh_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_BITS   = 16;
  localparam int ID_BITS    = 8;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = ADDR_W + 2;
  localparam int ENTRY_W    = 2 * KEY_BITS + ID_BITS;
  localparam int IN_DATA_W  = ((ENTRY_W + 7) / 8) * 8;
  localparam int OUT_W      = ENTRY_W + CNT_W;
  localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_POPPED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [KEY_BITS-1:0] g;
    logic [KEY_BITS-1:0] f;
  } entry_t;

  typedef struct packed {
    logic   cmd;
    entry_t entry;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic [CNT_W-1:0]   count;
    entry_t             entry;
  } res_t;

endpackage

FILE: design/fmh_cmp.sv
// ----------------------------------------------------------------------------
// fmh_cmp: heap order compare unit
// High when entry a ranks strictly above entry b: lower f, then lower g.
// ----------------------------------------------------------------------------
module fmh_cmp (
  input  fmh_pkg::entry_t a_i,
  input  fmh_pkg::entry_t b_i,
  output logic            before_o
);
  import fmh_pkg::*;

  always_comb begin
    if (a_i.f != b_i.f) begin
      before_o = (a_i.f < b_i.f);
    end else begin
      before_o = (a_i.g < b_i.g);
    end
  end

endmodule

FILE: design/fmh_ctrl.sv
// ----------------------------------------------------------------------------
// fmh_ctrl: heap sequencer and entry store
// Runs sift-up for an insert and hole walk plus sift-up for a pop, one tree
// level per read/compare pair, through one shared compare unit.
// ----------------------------------------------------------------------------
module fmh_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  fmh_pkg::item_t in_item_i,
  output logic           in_ready_o,
  output logic           res_valid_o,
  output fmh_pkg::res_t  res_o,
  input  logic           res_ready_i
);
  import fmh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_POP_LD,
    S_DN_CHK,
    S_DN_CMP,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  entry_t            ent_q, ent_d;
  entry_t            top_q, top_d;
  logic              cmd_q, cmd_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  res_t              res_q, res_d;

  entry_t            mem [CAPACITY];
  entry_t            rd_a_q, rd_b_q;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
  entry_t            wr_data;
  logic              we;

  entry_t            cmp_a;
  logic              a_first;
  logic [ADDR_W-1:0] parent;
  logic [IDX_W-1:0]  lc, rc, n_x;
  logic [CNT_W-1:0]  cnt_dec;
  logic              has_right;

  fmh_cmp u_cmp (
    .a_i      (cmp_a),
    .b_i      (rd_a_q),
    .before_o (a_first)
  );

  assign cmp_a     = (state_q == S_DN_CMP) ? rd_b_q : ent_q;
  assign parent    = (pos_q - ADDR_W'(1)) >> 1;
  assign lc        = {1'b0, pos_q, 1'b1};
  assign rc        = lc + IDX_W'(1);
  assign n_x       = IDX_W'(cnt_q);
  assign cnt_dec   = cnt_q - CNT_W'(1);
  assign has_right = (rc < n_x);

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  always_comb begin
    state_d   = state_q;
    ent_d     = ent_q;
    top_d     = top_q;
    cmd_d     = cmd_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    rd_addr_a = '0;
    rd_addr_b = '0;
    wr_addr   = pos_q;
    wr_data   = ent_q;
    we        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = in_item_i.cmd;
          if (in_item_i.cmd == CMD_INSERT) begin
            if (cnt_q >= CNT_W'(CAPACITY)) begin
              res_d   = '{status: ST_FULL, count: cnt_q, entry: '0};
              state_d = S_DONE;
            end else begin
              ent_d   = in_item_i.entry;
              pos_d   = cnt_q[ADDR_W-1:0];
              cnt_d   = cnt_q + CNT_W'(1);
              state_d = S_UP_CHK;
            end
          end else if (cnt_q == '0) begin
            res_d   = '{status: ST_EMPTY, count: cnt_q, entry: '0};
            state_d = S_DONE;
          end else begin
            cnt_d     = cnt_dec;
            rd_addr_a = '0;
            rd_addr_b = cnt_dec[ADDR_W-1:0];
            pos_d     = '0;
            state_d   = S_POP_LD;
          end
        end
      end
      S_UP_CHK: begin
        if (pos_q == '0) begin
          we = 1'b1;
          if (cmd_q == CMD_POP) begin
            res_d = '{status: ST_POPPED, count: cnt_q, entry: top_q};
          end else begin
            res_d = '{status: ST_INSERTED, count: cnt_q, entry: '0};
          end
          state_d = S_DONE;
        end else begin
          rd_addr_a = parent;
          state_d   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (a_first) begin
          wr_data = rd_a_q;
          pos_d   = parent;
          state_d = S_UP_CHK;
        end else begin
          if (cmd_q == CMD_POP) begin
            res_d = '{status: ST_POPPED, count: cnt_q, entry: top_q};
          end else begin
            res_d = '{status: ST_INSERTED, count: cnt_q, entry: '0};
          end
          state_d = S_DONE;
        end
      end
      S_POP_LD: begin
        top_d   = rd_a_q;
        ent_d   = rd_b_q;
        state_d = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (lc < n_x) begin
          rd_addr_a = lc[ADDR_W-1:0];
          rd_addr_b = has_right ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];
          state_d   = S_DN_CMP;
        end else begin
          state_d = S_UP_CHK;
        end
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (has_right && a_first) begin
          wr_data = rd_b_q;
          pos_d   = rc[ADDR_W-1:0];
        end else begin
          wr_data = rd_a_q;
          pos_d   = lc[ADDR_W-1:0];
        end
        state_d = S_DN_CHK;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      cmd_q   <= CMD_INSERT;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cmd_q   <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    top_q <= top_d;
    pos_q <= pos_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_q <= mem[rd_addr_a];
    rd_b_q <= mem[rd_addr_b];
  end

endmodule

FILE: design/frontier_min_heap_tiebreak_top.sv
// ----------------------------------------------------------------------------
// frontier_min_heap_tiebreak_top: A* frontier min-heap with g tie-break
//
// channel  dir  tdata (low bit up)                          tuser
// s_axis   in   f_key[15:0] g_key[31:16] node_id[39:32]      command
// m_axis   out  out_f_key[15:0] out_g_key[31:16]             status
//               out_node_id[39:32] entry_count[46:40] 0[47]
//
// One item at a time; an insert runs u levels of sift-up, and a pop runs d
// levels of hole walk and then u levels of sift-up. Each tree level costs
// one registered read of the entry store and one compare. A full insert or
// an empty pop walks no tree levels. Reset clears the fill count;
// the store itself needs no clearing. The result sits in an output register,
// so a new item is taken while the previous result waits on m_axis_tready_i.
// ----------------------------------------------------------------------------
module frontier_min_heap_tiebreak_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // f_key, g_key, node_id
  input  logic [fmh_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // command
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // out_f_key, out_g_key, out_node_id, entry_count, zero pad
  output logic [fmh_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // status
  output logic [1:0]                     m_axis_tuser_o
);
  import fmh_pkg::*;

  item_t                 in_item;
  res_t                  res;
  logic                  res_valid, res_ready;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [1:0]            out_user_q;

  assign in_item.cmd   = s_axis_tuser_i;
  assign in_item.entry = entry_t'(s_axis_tdata_i[ENTRY_W-1:0]);

  fmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_item_i   (in_item),
    .in_ready_o  (s_axis_tready_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= OUT_DATA_W'({res.count, res.entry});
      out_user_q <= res.status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule
